// ----- design/kpvt_pkg.sv -----
package kpvt_pkg;

    localparam int KEY_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 7;
    localparam int COUNT_W     = 7;
    localparam int ENTRIES_DEF = 96;

    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // operation that a pass down the cell row performs
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd0;  // empty first entry of owner
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;  // write value of first key match
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;  // fill first empty entry
    localparam logic [MODE_W-1:0] MODE_DETACH = 2'd3;  // empty all matching entries

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  owner;
        logic [KEY_W-1:0]  part;
        logic [KEY_W-1:0]  value;
        logic              all_parts;
    } op_t;

endpackage

// ----- design/kpvt_req_if.sv -----
interface kpvt_req_if import kpvt_pkg::*;;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [KEY_W-1:0] owner_key;
    logic [KEY_W-1:0] part_key;
    logic [KEY_W-1:0] new_value;

    modport source (output valid, cmd, owner_key, part_key, new_value, input ready);
    modport sink (input valid, cmd, owner_key, part_key, new_value, output ready);
endinterface

// ----- design/kpvt_rsp_if.sv -----
interface kpvt_rsp_if import kpvt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  removed_count;

    modport source (output valid, status, slot, removed_count, input ready);
    modport sink (input valid, status, slot, removed_count, output ready);
endinterface

// ----- design/keyed_pair_value_table.sv -----
// Keyed pair value table: ENTRIES entries of {owner, part, value}, owner
// 0xFFFF marks an empty entry.
// req channel (valid/ready): one command item (cmd, owner_key, part_key,
// new_value). rsp channel (valid/ready): exactly one result item per command
// (status, slot, removed_count).
// Entries live in a row of cells. A command launches a token that moves one
// cell per clock, and each cell compares and rewrites its own entry as the
// token passes; the token carries the done flag, first slot and count.
// An attach of a value that finds no owner/part match makes a second pass
// down the row to fill the first empty entry. One command is in the row at
// a time; req is ready again once the result enters the output register,
// so a new command waits for the token's walk down the row to finish.
// Reset empties every entry (owner, part and value all 0xFFFF) at once.
// A stalled rsp holds its item; a finished result waits in the sequencer
// and req stays low until the output register frees.
module keyed_pair_value_table import kpvt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    kpvt_req_if.sink  req,
    kpvt_rsp_if.source rsp
);

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_WW = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CNT_WW  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                launch_reg, launch_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_load;
    logic [SLOT_WW-1:0]  slot_wide;
    logic [CNT_WW-1:0]   count_wide;

    logic [ENTRIES:0]    t_valid;
    logic [ENTRIES:0]    t_done;
    logic [IDX_W-1:0]    t_idx   [ENTRIES+1];
    logic [IDX_W-1:0]    t_first [ENTRIES+1];
    logic [CNT_W-1:0]    t_count [ENTRIES+1];

    assign t_valid[0] = launch_reg;
    assign t_done[0]  = 1'b0;
    assign t_idx[0]   = '0;
    assign t_first[0] = '0;
    assign t_count[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            kpvt_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .op            (op_reg),
                .tok_valid_in  (t_valid[g]),
                .tok_done_in   (t_done[g]),
                .tok_idx_in    (t_idx[g]),
                .tok_first_in  (t_first[g]),
                .tok_count_in  (t_count[g]),
                .tok_valid_out (t_valid[g+1]),
                .tok_done_out  (t_done[g+1]),
                .tok_idx_out   (t_idx[g+1]),
                .tok_first_out (t_first[g+1]),
                .tok_count_out (t_count[g+1])
            );
        end
    endgenerate

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        launch_next     = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next.owner     = req.owner_key;
                    op_next.part      = req.part_key;
                    op_next.value     = req.new_value;
                    op_next.all_parts = (req.part_key == EMPTY_KEY);
                    if (!req.cmd)
                    begin
                        op_next.mode = MODE_DETACH;
                    end
                    else if (req.new_value == EMPTY_KEY)
                    begin
                        op_next.mode = MODE_REMOVE;
                    end
                    else
                    begin
                        op_next.mode = MODE_UPDATE;
                    end
                    launch_next = 1'b1;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                if (t_valid[ENTRIES])
                begin
                    state_next      = S_DONE;
                    res_slot_next   = t_first[ENTRIES];
                    res_count_next  = t_count[ENTRIES];
                    res_status_next = ST_NOMATCH;
                    if (!t_done[ENTRIES])
                    begin
                        res_slot_next  = '0;
                        res_count_next = '0;
                    end
                    unique case (op_reg.mode) inside
                        MODE_REMOVE, MODE_DETACH:
                        begin
                            res_status_next = t_done[ENTRIES] ? ST_REMOVED : ST_NOMATCH;
                        end
                        MODE_UPDATE:
                        begin
                            res_status_next = ST_UPDATED;
                            if (!t_done[ENTRIES])
                            begin
                                // no key match: second pass fills first empty entry
                                op_next.mode = MODE_INSERT;
                                launch_next  = 1'b1;
                                state_next   = S_RUN;
                            end
                        end
                        MODE_INSERT:
                        begin
                            res_status_next = t_done[ENTRIES] ? ST_INSERTED : ST_FULL;
                        end
                        default:
                        begin
                            res_status_next = ST_NOMATCH;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign slot_wide  = SLOT_WW'(res_slot_reg);
    assign count_wide = CNT_WW'(res_count_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= slot_wide[SLOT_W-1:0];
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.removed_count = out_count_reg;

    // only one token may walk the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({launch_reg, t_valid[ENTRIES:1]}))
        else $error("more than one token in the cell row");

    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (t_valid[ENTRIES] || launch_reg) |-> (state_reg == S_RUN))
        else $error("token in flight outside a run");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_NOMATCH || rsp.status == ST_FULL))
        |-> (rsp.slot == '0 && rsp.removed_count == '0))
        else $error("miss result with nonzero slot or count");

    a_count_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.removed_count != '0) |-> (rsp.status == ST_REMOVED))
        else $error("removed count on a non-remove result");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result load did not complete the command");

endmodule

// ----- design/kpvt_cell.sv -----
module kpvt_cell import kpvt_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter int CNT_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  op_t              op,
    input  logic             tok_valid_in,
    input  logic             tok_done_in,
    input  logic [IDX_W-1:0] tok_idx_in,
    input  logic [IDX_W-1:0] tok_first_in,
    input  logic [CNT_W-1:0] tok_count_in,
    output logic             tok_valid_out,
    output logic             tok_done_out,
    output logic [IDX_W-1:0] tok_idx_out,
    output logic [IDX_W-1:0] tok_first_out,
    output logic [CNT_W-1:0] tok_count_out
);

    logic [KEY_W-1:0] owner_reg, owner_next;
    logic [KEY_W-1:0] part_reg, part_next;
    logic [KEY_W-1:0] value_reg, value_next;
    logic             tok_valid_reg;
    logic             tok_done_reg, tok_done_next;
    logic [IDX_W-1:0] tok_idx_reg;
    logic [IDX_W-1:0] tok_first_reg, tok_first_next;
    logic [CNT_W-1:0] tok_count_reg, tok_count_next;
    logic             owner_hit;
    logic             part_hit;
    logic             act;
    logic             count_inc;

    assign owner_hit = (owner_reg == op.owner);
    assign part_hit  = (part_reg == op.part);

    always_comb
    begin
        owner_next = owner_reg;
        part_next  = part_reg;
        value_next = value_reg;
        act        = 1'b0;
        count_inc  = 1'b0;
        unique case (op.mode)
            MODE_REMOVE:
            begin
                act       = owner_hit && !tok_done_in;
                count_inc = act;
                if (act)
                begin
                    owner_next = EMPTY_KEY;
                    part_next  = EMPTY_KEY;
                end
            end
            MODE_UPDATE:
            begin
                act = owner_hit && part_hit && !tok_done_in;
                if (act)
                begin
                    value_next = op.value;
                end
            end
            MODE_INSERT:
            begin
                act = (owner_reg == EMPTY_KEY) && !tok_done_in;
                if (act)
                begin
                    owner_next = op.owner;
                    part_next  = op.part;
                    value_next = op.value;
                end
            end
            MODE_DETACH:
            begin
                act       = owner_hit && (op.all_parts || part_hit);
                count_inc = act;
                if (act)
                begin
                    owner_next = EMPTY_KEY;
                    part_next  = EMPTY_KEY;
                    value_next = EMPTY_KEY;
                end
            end
            default:
            begin
                act = 1'b0;
            end
        endcase
        tok_done_next  = tok_done_in || act;
        tok_first_next = (act && !tok_done_in) ? tok_idx_in : tok_first_in;
        tok_count_next = tok_count_in + CNT_W'(count_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg     <= EMPTY_KEY;
            part_reg      <= EMPTY_KEY;
            value_reg     <= EMPTY_KEY;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
            if (tok_valid_in)
            begin
                owner_reg <= owner_next;
                part_reg  <= part_next;
                value_reg <= value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_done_reg  <= tok_done_next;
        tok_idx_reg   <= tok_idx_in + IDX_W'(1);
        tok_first_reg <= tok_first_next;
        tok_count_reg <= tok_count_next;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_done_out  = tok_done_reg;
    assign tok_idx_out   = tok_idx_reg;
    assign tok_first_out = tok_first_reg;
    assign tok_count_out = tok_count_reg;

endmodule

// ----- tb/table_tb_pkg.sv -----
`timescale 1ns / 100ps

package table_tb_pkg;

    // command codes on the req channel
    localparam logic CMD_DETACH = 1'b0;
    localparam logic CMD_ATTACH = 1'b1;

    localparam int NUM_STATUS = 5;

endpackage

// ----- tb/table_checker.sv -----
`timescale 1ns / 100ps

module table_checker import kpvt_pkg::*, table_tb_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    kpvt_req_if  req,
    kpvt_rsp_if  rsp,
    output int   error_count,
    output int   pending,
    output int   status_hits [NUM_STATUS],
    output int   peak_fill
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  removed_count;
    } table_result_t;

    logic [KEY_W-1:0] owner_tab [ENTRIES];
    logic [KEY_W-1:0] part_tab  [ENTRIES];
    logic [KEY_W-1:0] value_tab [ENTRIES];

    table_result_t expected_results [$];

    // applies one command to the shadow table and returns its result
    function automatic table_result_t run_command(input logic cmd,
                                                  input logic [KEY_W-1:0] owner,
                                                  input logic [KEY_W-1:0] part,
                                                  input logic [KEY_W-1:0] value);
        table_result_t res;
        int hit;
        int removed;
        res.status        = ST_NOMATCH;
        res.slot          = '0;
        res.removed_count = '0;
        hit               = -1;
        removed           = 0;
        if (cmd == CMD_ATTACH && value == EMPTY_KEY)
        begin
            // value kept, only the key is cleared
            for (int i = 0; i < ENTRIES; i++)
                if (hit < 0 && owner_tab[i] == owner)
                    hit = i;
            if (hit >= 0)
            begin
                owner_tab[hit]    = EMPTY_KEY;
                part_tab[hit]     = EMPTY_KEY;
                res.status        = ST_REMOVED;
                res.slot          = SLOT_W'(hit);
                res.removed_count = COUNT_W'(1);
            end
        end
        else if (cmd == CMD_ATTACH)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (hit < 0 && owner_tab[i] == owner && part_tab[i] == part)
                    hit = i;
            if (hit >= 0)
            begin
                value_tab[hit] = value;
                res.status     = ST_UPDATED;
                res.slot       = SLOT_W'(hit);
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (hit < 0 && owner_tab[i] == EMPTY_KEY)
                        hit = i;
                if (hit >= 0)
                begin
                    owner_tab[hit] = owner;
                    part_tab[hit]  = part;
                    value_tab[hit] = value;
                    res.status     = ST_INSERTED;
                    res.slot       = SLOT_W'(hit);
                end
                else
                    res.status = ST_FULL;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (owner_tab[i] == owner && (part == EMPTY_KEY || part_tab[i] == part))
                begin
                    owner_tab[i] = EMPTY_KEY;
                    part_tab[i]  = EMPTY_KEY;
                    value_tab[i] = EMPTY_KEY;
                    if (removed == 0)
                        res.slot = SLOT_W'(i);
                    removed++;
                end
            end
            if (removed > 0)
            begin
                res.status        = ST_REMOVED;
                res.removed_count = COUNT_W'(removed);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        table_result_t want;
        int fails;
        int fill;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                owner_tab[i] = EMPTY_KEY;
                part_tab[i]  = EMPTY_KEY;
                value_tab[i] = EMPTY_KEY;
            end
            expected_results.delete();
            error_count <= 0;
            pending     <= 0;
            peak_fill   <= 0;
            for (int s = 0; s < NUM_STATUS; s++)
                status_hits[s] <= 0;
        end
        else
        begin
            fails = 0;
            // results first: a result never belongs to a command taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d slot %0d removed_count %0d",
                           rsp.status, rsp.slot, rsp.removed_count);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        fails++;
                    end
                    if (rsp.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
                        fails++;
                    end
                    if (rsp.removed_count !== want.removed_count)
                    begin
                        $error("removed_count: expected %0d, actual %0d",
                               want.removed_count, rsp.removed_count);
                        fails++;
                    end
                    status_hits[want.status] <= status_hits[want.status] + 1;
                end
            end
            if (req.valid && req.ready)
            begin
                expected_results.push_back(run_command(req.cmd, req.owner_key,
                                                       req.part_key, req.new_value));
                fill = 0;
                for (int i = 0; i < ENTRIES; i++)
                    if (owner_tab[i] != EMPTY_KEY)
                        fill++;
                if (fill > peak_fill)
                    peak_fill <= fill;
            end
            pending     <= expected_results.size();
            error_count <= error_count + fails;
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench import kpvt_pkg::*, table_tb_pkg::*;;

    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_LEN    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int OWNER_POOL   = 12;
    localparam int PART_POOL    = 16;

    localparam int STALL_NONE    = 0;
    localparam int STALL_PATTERN = 1;
    localparam int STALL_RANDOM  = 2;

    logic clk;
    logic rst_n;

    int error_count;
    int pending;
    int peak_fill;
    int status_hits [NUM_STATUS];

    int items_sent;
    int burst_left;
    int idle_cycles;
    int stall_tick;
    int stall_mode;
    logic [7:0] stall_mask = 8'hFF;

    logic [KEY_W-1:0] owner_pool [OWNER_POOL];
    logic [KEY_W-1:0] part_pool  [PART_POOL];

    kpvt_req_if req ();
    kpvt_rsp_if rsp ();

    keyed_pair_value_table dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    table_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .error_count (error_count),
        .pending     (pending),
        .status_hits (status_hits),
        .peak_fill   (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] owner,
                             input logic [KEY_W-1:0] part, input logic [KEY_W-1:0] value);
        req.cmd       <= cmd;
        req.owner_key <= owner;
        req.part_key  <= part;
        req.new_value <= value;
        req.valid     <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic pace_sender();
        int pick;
        int gap_len;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                gap_len = $urandom_range(1, 4);
            else if (pick < 9)
                gap_len = $urandom_range(5, 120);
            else
                gap_len = $urandom_range(121, 250);
            req.valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // fill phases mostly attach so the table reaches full; churn phases mix removals
    task automatic random_command(input bit filling);
        int pick;
        logic c;
        logic [KEY_W-1:0] o;
        logic [KEY_W-1:0] p;
        logic [KEY_W-1:0] v;
        pick = $urandom_range(0, 99);
        c    = CMD_ATTACH;
        o    = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
        p    = part_pool[$urandom_range(0, PART_POOL - 1)];
        v    = KEY_W'($urandom_range(0, 16'hFFFE));
        if (filling)
        begin
            if (pick >= 96)
            begin
                c = 1'($urandom_range(0, 1));
                o = KEY_W'($urandom);
                p = KEY_W'($urandom);
                v = KEY_W'($urandom);
            end
            else if (pick >= 92)
                c = CMD_DETACH;
            else if (pick >= 88)
                v = EMPTY_KEY;
        end
        else
        begin
            if (pick >= 92)
            begin
                // empty marker used as an owner
                c = 1'($urandom_range(0, 1));
                o = EMPTY_KEY;
                if ($urandom_range(0, 1) == 0)
                    p = EMPTY_KEY;
                v = KEY_W'($urandom);
            end
            else if (pick >= 84)
            begin
                c = 1'($urandom_range(0, 1));
                o = KEY_W'($urandom);
                p = KEY_W'($urandom);
                v = KEY_W'($urandom);
            end
            else if (pick >= 76)
            begin
                c = CMD_DETACH;
                p = EMPTY_KEY;
            end
            else if (pick >= 62)
                c = CMD_DETACH;
            else if (pick >= 50)
                v = EMPTY_KEY;
        end
        send_item(c, o, p, v);
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.cmd       <= CMD_DETACH;
        req.owner_key <= '0;
        req.part_key  <= '0;
        req.new_value <= '0;
        items_sent = 0;
        burst_left = 0;
        for (int i = 0; i < OWNER_POOL; i++)
            owner_pool[i] = KEY_W'($urandom_range(0, 16'hFFFE));
        for (int i = 0; i < PART_POOL; i++)
            part_pool[i] = KEY_W'($urandom_range(0, 16'hFFFE));
        owner_pool[0] = '0;
        owner_pool[1] = 16'hFFFE;
        part_pool[0]  = '0;
        part_pool[1]  = 16'hFFFE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, update, insert, remove, marker keys, wide detach
        send_item(CMD_DETACH, 16'h0000, EMPTY_KEY, 16'h0000);
        send_item(CMD_ATTACH, 16'h0000, 16'h0000, EMPTY_KEY);
        send_item(CMD_ATTACH, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_ATTACH, 16'h0000, 16'h0000, 16'hFFFE);
        send_item(CMD_ATTACH, 16'h0000, 16'hFFFE, 16'h0001);
        send_item(CMD_ATTACH, 16'hFFFE, 16'h0000, 16'h8000);
        send_item(CMD_ATTACH, 16'hFFFE, EMPTY_KEY, 16'h7FFF);
        send_item(CMD_ATTACH, 16'h0000, 16'hFFFE, EMPTY_KEY);
        send_item(CMD_ATTACH, EMPTY_KEY, EMPTY_KEY, 16'h1234);
        send_item(CMD_ATTACH, EMPTY_KEY, EMPTY_KEY, EMPTY_KEY);
        send_item(CMD_ATTACH, EMPTY_KEY, 16'h0005, 16'hAAAA);
        send_item(CMD_DETACH, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_DETACH, 16'h0000, 16'hFFFE, 16'h5555);
        send_item(CMD_ATTACH, 16'h1234, 16'h0001, 16'h5555);
        send_item(CMD_ATTACH, 16'h1234, 16'h0002, 16'hAAAA);
        send_item(CMD_ATTACH, 16'h1234, 16'h0003, 16'h0000);
        send_item(CMD_DETACH, 16'h1234, EMPTY_KEY, 16'h0000);
        send_item(CMD_DETACH, 16'hFFFE, EMPTY_KEY, EMPTY_KEY);
        send_item(CMD_DETACH, EMPTY_KEY, 16'h0005, 16'h0000);
        send_item(CMD_DETACH, EMPTY_KEY, EMPTY_KEY, 16'h0000);
        send_item(CMD_ATTACH, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_DETACH, EMPTY_KEY, 16'h0000, 16'h0000);
        wait_for_results();

        for (phase = 0; phase < RANDOM_ITEMS / PHASE_LEN; phase++)
        begin
            for (n = 0; n < PHASE_LEN; n++)
            begin
                random_command(phase % 2 == 0);
                pace_sender();
            end
            wait_for_results();
        end

        repeat (2 * ENTRIES_DEF + 8) @(posedge clk);
        $display("Covered %0d commands: updated %0d, inserted %0d, removed %0d, no match %0d,",
                 items_sent, status_hits[ST_UPDATED], status_hits[ST_INSERTED],
                 status_hits[ST_REMOVED], status_hits[ST_NOMATCH]);
        $display("  table full %0d times, peak occupancy %0d of %0d entries",
                 status_hits[ST_FULL], peak_fill, ENTRIES_DEF);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver: stall_tick switches it among no stall, a repeating mask, or random ready
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 300 == 0)
        begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_RANDOM);
            stall_mask <= 8'($urandom) | 8'h01;
        end
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            case (stall_mode)
                STALL_NONE:    rsp.ready <= 1'b1;
                STALL_PATTERN: rsp.ready <= stall_mask[stall_tick % 8];
                default:       rsp.ready <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no item moved on either channel for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
